>>> design/pn_pkg.sv
`timescale 1ns / 1ps

package pn_pkg;

  localparam int MAX_PATH_LEN_DEF = 256;
  localparam int STACK_DEPTH_DEF  = 128;

  localparam logic KEEP_ROOT_RST = 1'b1;
  localparam logic REG_KEEP_ROOT = 1'b0;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_DOT1  = 2'd1;
  localparam logic [1:0] KIND_DOT2  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  typedef struct packed {
    logic feed;
    logic finish;
    logic issue;
    logic clear;
  } pn_cmd_t;

  typedef struct packed {
    logic rd_free;
    logic last_chunk;
  } pn_status_t;

endpackage

>>> design/pn_ctrl.sv
`timescale 1ns / 1ps

module pn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  pn_pkg::pn_status_t stat,
  output pn_pkg::pn_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FINISH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.feed = 1'b1;
          if (s_tlast) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.rd_free) begin
          cmd.issue = 1'b1;
          if (stat.last_chunk) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/pn_datapath.sv
`timescale 1ns / 1ps

module pn_datapath #(
  parameter int MAX_PATH_LEN = pn_pkg::MAX_PATH_LEN_DEF,
  parameter int STACK_DEPTH  = pn_pkg::STACK_DEPTH_DEF,
  localparam int LEN_W = $clog2(MAX_PATH_LEN + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               keep_root,
  input  logic [7:0]         char_in,
  input  pn_pkg::pn_cmd_t    cmd,
  output pn_pkg::pn_status_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [63:0]        chunk,
  output logic [3:0]         chunk_bytes,
  output logic [LEN_W-1:0]   path_length,
  output logic               status,
  output logic               last_out
);

  localparam int NUM_WORDS = (MAX_PATH_LEN + 7) / 8;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int OFW       = $clog2(MAX_PATH_LEN);
  localparam int SPW       = $clog2(STACK_DEPTH + 1);
  localparam int SIW       = $clog2(STACK_DEPTH);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PATH_LEN);
  localparam logic [SPW-1:0]   MAX_DEPTH = SPW'(STACK_DEPTH);

  // per-path state
  logic [LEN_W-1:0] wp, wp_next;
  logic [LEN_W-1:0] count, count_next;
  logic [LEN_W-1:0] comp_start, comp_start_next;
  logic [SPW-1:0]   sp, sp_next;
  logic [1:0]       kind, kind_next;
  logic             started, started_next;
  logic             ended, ended_next;
  logic             error, error_next;
  logic [OFW-1:0]   top;

  logic [63:0]      buf_mem [NUM_WORDS];
  logic [OFW-1:0]   stack_mem [STACK_DEPTH];

  logic             do_put, do_write, do_push, do_pop, fin, fin_sep, is_sep;
  logic [7:0]       put_char;

  // chunk read side
  logic [AW-1:0]    k;
  logic [LEN_W-1:0] len, base, rem;
  logic [3:0]       cnt;
  logic             last_chunk;
  logic [63:0]      rd_word;
  logic             s1_valid, s1_status, s1_last, advance;
  logic [3:0]       s1_cnt;
  logic [LEN_W-1:0] s1_len;
  logic [63:0]      mask;

  assign is_sep = (char_in == pn_pkg::CHAR_SLASH) || (char_in == pn_pkg::CHAR_BSLASH);

  always_comb begin
    wp_next         = wp;
    count_next      = count;
    comp_start_next = comp_start;
    sp_next         = sp;
    kind_next       = kind;
    started_next    = started;
    ended_next      = ended;
    error_next      = error;
    do_put          = 1'b0;
    do_write        = 1'b0;
    do_push         = 1'b0;
    do_pop          = 1'b0;
    fin             = 1'b0;
    fin_sep         = 1'b0;
    put_char        = char_in;
    if (cmd.clear) begin
      wp_next         = '0;
      count_next      = '0;
      comp_start_next = '0;
      sp_next         = '0;
      kind_next       = pn_pkg::KIND_EMPTY;
      started_next    = 1'b0;
      ended_next      = 1'b0;
      error_next      = 1'b0;
    end else begin
      if (cmd.feed && !ended && !error) begin
        if (char_in == pn_pkg::CHAR_NUL) begin
          ended_next = 1'b1;
        end else if (count >= MAX_LEN) begin
          error_next = 1'b1;
        end else begin
          count_next   = count + LEN_W'(1);
          started_next = 1'b1;
          if (is_sep) begin
            if (kind != pn_pkg::KIND_EMPTY) begin
              fin     = 1'b1;
              fin_sep = 1'b1;
            end else if (!started && keep_root) begin
              do_put   = 1'b1;
              put_char = pn_pkg::CHAR_SLASH;
            end
          end else begin
            if (kind == pn_pkg::KIND_EMPTY) begin
              comp_start_next = wp;
            end
            do_put = 1'b1;
            if (char_in == pn_pkg::CHAR_DOT && kind == pn_pkg::KIND_EMPTY) begin
              kind_next = pn_pkg::KIND_DOT1;
            end else if (char_in == pn_pkg::CHAR_DOT && kind == pn_pkg::KIND_DOT1) begin
              kind_next = pn_pkg::KIND_DOT2;
            end else begin
              kind_next = pn_pkg::KIND_OTHER;
            end
          end
        end
      end else if (cmd.finish && !error) begin
        fin = 1'b1;
      end
      // close the current component
      if (fin) begin
        kind_next = pn_pkg::KIND_EMPTY;
        if (kind == pn_pkg::KIND_DOT2) begin
          if (sp != '0) begin
            do_pop = 1'b1;
          end else if (fin_sep) begin
            do_put   = 1'b1;
            put_char = pn_pkg::CHAR_SLASH;
          end
        end else if (kind != pn_pkg::KIND_EMPTY) begin
          if (sp >= MAX_DEPTH) begin
            error_next = 1'b1;
          end else begin
            do_push = 1'b1;
            if (fin_sep) begin
              do_put   = 1'b1;
              put_char = pn_pkg::CHAR_SLASH;
            end
          end
        end
      end
      if (do_pop) begin
        sp_next = sp - SPW'(1);
        wp_next = LEN_W'(top);
      end
      if (do_push) begin
        sp_next = sp + SPW'(1);
      end
      if (do_put) begin
        if (wp >= MAX_LEN) begin
          error_next = 1'b1;
        end else begin
          do_write = 1'b1;
          wp_next  = wp + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      count      <= '0;
      comp_start <= '0;
      sp         <= '0;
      kind       <= pn_pkg::KIND_EMPTY;
      started    <= 1'b0;
      ended      <= 1'b0;
      error      <= 1'b0;
    end else begin
      wp         <= wp_next;
      count      <= count_next;
      comp_start <= comp_start_next;
      sp         <= sp_next;
      kind       <= kind_next;
      started    <= started_next;
      ended      <= ended_next;
      error      <= error_next;
    end
  end

  // offset stack, top of stack kept in a register
  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[sp[SIW-1:0]] <= comp_start[OFW-1:0];
      top                    <= comp_start[OFW-1:0];
    end else if (do_pop) begin
      top <= stack_mem[SIW'(sp - SPW'(2))];
    end
  end

  // path buffer, one 64-bit word per chunk
  always_ff @(posedge clk) begin
    if (do_write) begin
      buf_mem[wp[3 +: AW]][{wp[2:0], 3'b000} +: 8] <= put_char;
    end
    if (cmd.issue) begin
      rd_word <= buf_mem[k];
    end
  end

  assign len        = error ? '0 : wp;
  assign base       = LEN_W'({k, 3'b000});
  assign rem        = len - base;
  assign last_chunk = (rem <= LEN_W'(8));
  assign cnt        = last_chunk ? rem[3:0] : 4'd8;
  assign advance    = s1_valid && (!out_valid || out_ready);

  assign stat.rd_free    = !s1_valid || advance;
  assign stat.last_chunk = last_chunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.clear) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_cnt    <= cnt;
      s1_len    <= len;
      s1_status <= error;
      s1_last   <= last_chunk;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i*8 +: 8] = (4'(i) < s1_cnt) ? 8'hFF : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.issue) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      chunk       <= rd_word & mask;
      chunk_bytes <= s1_cnt;
      path_length <= s1_len;
      status      <= s1_status;
      last_out    <= s1_last;
    end
  end

endmodule

>>> design/path_normalizer.sv
`timescale 1ns / 1ps

// Lexical path normalizer. A path streams in one byte per request with tlast on the
// final byte; the block folds separator runs to one '/', keeps or drops the leading
// root per keep_root, resolves ".." against a stack of component offsets, and stops
// at a zero byte. After the final byte a finish state closes the last component,
// then the result leaves as ceil(length/8) chunks (at least one), one per cycle
// unless the output stalls, from the word-wide read port of the path buffer via a
// read register and an output register. Input is held off from the final byte
// until the last chunk has been read from the buffer. Too long input or stack
// overflow gives status 1 and length 0 in a single empty chunk.
module path_normalizer #(
  parameter int MAX_PATH_LEN = pn_pkg::MAX_PATH_LEN_DEF,
  parameter int STACK_DEPTH  = pn_pkg::STACK_DEPTH_DEF,
  localparam int LEN_W   = $clog2(MAX_PATH_LEN + 1),
  localparam int TDATA_W = ((64 + 4 + LEN_W + 1 + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // char_in
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // chunk, chunk_bytes, path_length, status
  output logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic               keep_root;
  logic               cfg_hit;
  pn_pkg::pn_cmd_t    cmd;
  pn_pkg::pn_status_t stat;
  logic [63:0]        chunk;
  logic [3:0]         chunk_bytes;
  logic [LEN_W-1:0]   path_length;
  logic               status;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == pn_pkg::REG_KEEP_ROOT);
  assign prdata  = cfg_hit ? {31'b0, keep_root} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_root <= pn_pkg::KEEP_ROOT_RST;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      keep_root <= pwdata[0];
    end
  end

  pn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pn_datapath #(
    .MAX_PATH_LEN (MAX_PATH_LEN),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .keep_root   (keep_root),
    .char_in     (s_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .chunk       (chunk),
    .chunk_bytes (chunk_bytes),
    .path_length (path_length),
    .status      (status),
    .last_out    (m_tlast)
  );

  assign m_tdata = TDATA_W'({status, path_length, chunk_bytes, chunk});

endmodule

>>> verif/path_normalizer_tb.sv
`timescale 1ns / 1ps

module path_normalizer_tb;

  localparam int MAX_LEN   = pn_pkg::MAX_PATH_LEN_DEF;
  localparam int STK_DEPTH = pn_pkg::STACK_DEPTH_DEF;

  typedef struct packed {
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic [8:0]  plen;
    logic        status;
    logic        last;
  } path_chunk_t;

  class path_scoreboard;
    bit            keep_root;
    logic [7:0]    path_mem [MAX_LEN];
    logic [8:0]    ofs_mem [STK_DEPTH];
    int unsigned   wr_ptr;
    int unsigned   sp;
    int unsigned   comp_start;
    int unsigned   byte_cnt;
    logic [1:0]    kind;
    bit            started;
    bit            ended;
    bit            err;
    path_chunk_t   chunk_q[$];
    int            errors;

    function void clear_path();
      wr_ptr     = 0;
      sp         = 0;
      comp_start = 0;
      byte_cnt   = 0;
      kind       = pn_pkg::KIND_EMPTY;
      started    = 0;
      ended      = 0;
      err        = 0;
    endfunction

    function void put_byte(logic [7:0] c);
      if (wr_ptr >= MAX_LEN) begin
        err = 1;
        return;
      end
      path_mem[wr_ptr] = c;
      wr_ptr++;
    endfunction

    function void finish_component(bit with_sep);
      if (kind == pn_pkg::KIND_DOT2) begin
        if (sp > 0) begin
          sp--;
          wr_ptr = ofs_mem[sp];
        end else if (with_sep) begin
          put_byte(pn_pkg::CHAR_SLASH);
        end
      end else if (kind != pn_pkg::KIND_EMPTY) begin
        if (sp >= STK_DEPTH) begin
          err = 1;
        end else begin
          ofs_mem[sp] = comp_start[8:0];
          sp++;
        end
        if (with_sep && !err) put_byte(pn_pkg::CHAR_SLASH);
      end
      kind = pn_pkg::KIND_EMPTY;
    endfunction

    function void feed_byte(logic [7:0] c);
      bit first;
      if (ended || err) return;
      if (c == pn_pkg::CHAR_NUL) begin
        ended = 1;
        return;
      end
      if (byte_cnt >= MAX_LEN) begin
        err = 1;
        return;
      end
      byte_cnt++;
      first   = !started;
      started = 1;
      if (c == pn_pkg::CHAR_SLASH || c == pn_pkg::CHAR_BSLASH) begin
        if (kind != pn_pkg::KIND_EMPTY) finish_component(1);
        else if (first && keep_root) put_byte(pn_pkg::CHAR_SLASH);
        return;
      end
      if (kind == pn_pkg::KIND_EMPTY) comp_start = wr_ptr;
      put_byte(c);
      if (c == pn_pkg::CHAR_DOT && kind == pn_pkg::KIND_EMPTY) kind = pn_pkg::KIND_DOT1;
      else if (c == pn_pkg::CHAR_DOT && kind == pn_pkg::KIND_DOT1) kind = pn_pkg::KIND_DOT2;
      else kind = pn_pkg::KIND_OTHER;
    endfunction

    function void note_byte(logic [7:0] c, logic l);
      int unsigned len;
      int unsigned n;
      int unsigned cnt;
      path_chunk_t e;
      feed_byte(c);
      if (!l) return;
      if (!err) finish_component(0);
      len = err ? 0 : wr_ptr;
      if (len > MAX_LEN) len = MAX_LEN;
      n = (len + 7) / 8;
      if (n == 0) n = 1;
      for (int unsigned k = 0; k < n; k++) begin
        cnt = (len > k * 8) ? len - k * 8 : 0;
        if (cnt > 8) cnt = 8;
        e.chunk = '0;
        for (int unsigned i = 0; i < cnt; i++) e.chunk[8*i +: 8] = path_mem[k*8 + i];
        e.nbytes = cnt[3:0];
        e.plen   = len[8:0];
        e.status = err;
        e.last   = (k + 1 == n);
        chunk_q.push_back(e);
      end
      clear_path();
    endfunction

    function void check_chunk(logic [79:0] d, logic l);
      path_chunk_t e;
      if (chunk_q.size() == 0) begin
        $display("%0t: unexpected chunk, expected none, actual %h last %b", $time, d, l);
        errors++;
        return;
      end
      e = chunk_q.pop_front();
      if (d[63:0] !== e.chunk) begin
        $display("%0t: chunk mismatch, expected %h, actual %h", $time, e.chunk, d[63:0]);
        errors++;
      end
      if (d[67:64] !== e.nbytes) begin
        $display("%0t: chunk_bytes mismatch, expected %0d, actual %0d", $time, e.nbytes,
                 d[67:64]);
        errors++;
      end
      if (d[76:68] !== e.plen) begin
        $display("%0t: path_length mismatch, expected %0d, actual %0d", $time, e.plen,
                 d[76:68]);
        errors++;
      end
      if (d[77] !== e.status) begin
        $display("%0t: status mismatch, expected %b, actual %b", $time, e.status, d[77]);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last mismatch, expected %b, actual %b", $time, e.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return chunk_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // char_in
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // chunk, chunk_bytes, path_length, status
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  path_scoreboard sb;
  bit             idle_on;
  bit             hold_req;
  logic [7:0]     path_q[$];

  path_normalizer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #10_000_000;
    $display("path_normalizer regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_chunk(m_tdata, m_tlast);
  end

  // result side
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (hold_req) begin
        gap      = 300;
        hold_req = 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_byte(logic [7:0] c, logic l);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(c, l);
  endtask

  task automatic send_path();
    for (int i = 0; i < path_q.size(); i++) send_byte(path_q[i], i == path_q.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_keep_root(logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(pn_pkg::REG_KEEP_ROOT) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.keep_root = value[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] sep_byte();
    return $urandom_range(0, 1) ? pn_pkg::CHAR_SLASH : pn_pkg::CHAR_BSLASH;
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == pn_pkg::CHAR_SLASH || b == pn_pkg::CHAR_BSLASH);
    return b;
  endfunction

  task automatic build_formed();
    int ncomp;
    path_q.delete();
    repeat ($urandom_range(0, 3)) path_q.push_back(sep_byte());
    ncomp = $urandom_range(0, 6);
    for (int k = 0; k < ncomp; k++) begin
      if (k > 0) repeat ($urandom_range(1, 3)) path_q.push_back(sep_byte());
      case ($urandom_range(0, 5))
        0: path_q.push_back(pn_pkg::CHAR_DOT);
        1, 2: begin
          path_q.push_back(pn_pkg::CHAR_DOT);
          path_q.push_back(pn_pkg::CHAR_DOT);
        end
        default: repeat ($urandom_range(1, 4)) path_q.push_back(name_byte());
      endcase
    end
    if ($urandom_range(0, 3) == 0) path_q.push_back(sep_byte());
    if ($urandom_range(0, 9) == 0) begin
      path_q.push_back(pn_pkg::CHAR_NUL);
      repeat ($urandom_range(1, 3)) path_q.push_back(8'($urandom_range(0, 255)));
    end
    if (path_q.size() == 0) path_q.push_back(name_byte());
  endtask

  task automatic build_noise();
    path_q.delete();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 3))
        0: path_q.push_back(pn_pkg::CHAR_DOT);
        1: path_q.push_back(sep_byte());
        default: path_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic build_long_name(int n);
    path_q.delete();
    repeat (n) path_q.push_back(name_byte());
  endtask

  task automatic build_deep();
    path_q.delete();
    repeat (MAX_LEN / 2) begin
      path_q.push_back(name_byte());
      path_q.push_back(sep_byte());
    end
  endtask

  initial begin
    int phase_bytes;
    sb       = new();
    sb.keep_root = pn_pkg::KEEP_ROOT_RST;
    sb.clear_path();
    sb.errors = 0;
    idle_on  = 1;
    hold_req = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // root kept, separator runs, dot-dot pops
    path_q = '{pn_pkg::CHAR_BSLASH, pn_pkg::CHAR_SLASH, "x", pn_pkg::CHAR_BSLASH,
               pn_pkg::CHAR_DOT, pn_pkg::CHAR_DOT};
    send_path();
    // dot-dot with empty stack then backslash
    path_q = '{pn_pkg::CHAR_DOT, pn_pkg::CHAR_DOT, pn_pkg::CHAR_BSLASH, "b"};
    send_path();
    // single dot and trailing separator
    path_q = '{pn_pkg::CHAR_DOT, pn_pkg::CHAR_SLASH, "a", pn_pkg::CHAR_SLASH};
    send_path();
    // zero byte ends the path early
    path_q = '{"q", pn_pkg::CHAR_NUL, "z", 8'hFF};
    send_path();
    // extreme byte values
    path_q = '{8'hFF, 8'h01, 8'h80};
    send_path();
    // empty result, then a path of separators only
    path_q = '{pn_pkg::CHAR_NUL};
    send_path();
    path_q = '{pn_pkg::CHAR_SLASH, pn_pkg::CHAR_SLASH};
    send_path();

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_keep_root({31'($urandom_range(0, 32'h7FFF_FFFF)),
                       (ph == 4) ? 1'($urandom_range(0, 1)) : 1'(ph % 2)});
      idle_on = (ph != 2 && ph != 3);
      if (ph == 2) hold_req = 1;
      case (ph)
        0: begin
          path_q = '{pn_pkg::CHAR_SLASH, "a"};
          send_path();
        end
        1: begin
          build_formed();
          send_path();
        end
        2: begin
          build_deep();
          send_path();
        end
        3: begin
          build_long_name(MAX_LEN + 1 + $urandom_range(0, 3));
          send_path();
        end
        default: begin
          build_formed();
          send_path();
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 10) begin
        if ($urandom_range(0, 4) == 0) build_noise();
        else build_formed();
        send_path();
        phase_bytes += path_q.size();
        if (ph != 2 && $urandom_range(0, 7) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("path_normalizer regression: pass");
    end else begin
      $display("path_normalizer regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/pn_pkg.sv
design/pn_ctrl.sv
design/pn_datapath.sv
design/path_normalizer.sv
verif/path_normalizer_tb.sv
